// ===== hw/rtl/elo_pkg.sv =====
// Shared types, constants and helpers for the encoder line odometry block.
// Used by every module under hw/rtl; depends on nothing.
package elo_pkg;

  localparam int LINE_LEN_DEF     = 32;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // Long divider: dividend and divisor widths
  localparam int DIV_NW = 73;
  localparam int DIV_DW = 40;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_CIRC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_REV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_DISC   = 3'd4;
  localparam int CFG_DATA_W = 24;

  localparam logic [23:0] RST_WHEEL_CIRC    = 24'd36045;
  localparam logic [23:0] RST_TRACK_WIDTH   = 24'd58327;
  localparam logic [15:0] RST_COUNTS_REV    = 16'd4096;
  localparam logic [15:0] RST_STALE_TIMEOUT = 16'd1000;
  localparam logic [7:0]  RST_FRAMES_DISC   = 8'd5;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_BYTE = 1'b1;
  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_ODOM    = 1'b1;

  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  localparam logic [29:0] KINV_Q30       = 30'd652032874;
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [9:0]  MS_PER_S       = 10'd1000;

  // Number parser phases
  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_DIGIT = 2'd1;
  localparam logic [1:0] PH_STOP  = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] yaw_rate;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [23:0] wheel_circ_q16;
    logic [23:0] track_width_q16;
    logic [15:0] counts_per_rev;
    logic [15:0] stale_timeout_ms;
    logic [7:0]  frames_to_discard;
  } cfg_t;

  // One queue entry per input that causes results
  typedef struct packed {
    logic               has_rst;
    logic               has_job;
    logic signed [31:0] right;
    logic signed [31:0] left;
    logic [31:0]        dt;
  } job_t;

  typedef struct packed {
    logic [1:0]  ph;
    logic        neg;
    logic [31:0] mag;
  } prs_t;

  // CORDIC arctangent, 2^32 units per turn
  function automatic logic [29:0] atan_q32(input logic [4:0] idx);
    logic [29:0] a;
    begin
      case (idx)
        5'd0:  a = 30'd536870912;
        5'd1:  a = 30'd316933406;
        5'd2:  a = 30'd167458907;
        5'd3:  a = 30'd85004756;
        5'd4:  a = 30'd42667331;
        5'd5:  a = 30'd21354465;
        5'd6:  a = 30'd10679838;
        5'd7:  a = 30'd5340245;
        5'd8:  a = 30'd2670163;
        5'd9:  a = 30'd1335087;
        5'd10: a = 30'd667544;
        5'd11: a = 30'd333772;
        5'd12: a = 30'd166886;
        5'd13: a = 30'd83443;
        5'd14: a = 30'd41722;
        5'd15: a = 30'd20861;
        5'd16: a = 30'd10430;
        5'd17: a = 30'd5215;
        5'd18: a = 30'd2608;
        5'd19: a = 30'd1304;
        5'd20: a = 30'd652;
        5'd21: a = 30'd326;
        5'd22: a = 30'd163;
        5'd23: a = 30'd81;
        default: a = 30'd0;
      endcase
      return a;
    end
  endfunction

endpackage

// ===== hw/rtl/encoder_line_odometry.sv =====
// Wheel odometry from a serial encoder-count stream. Each input transaction (a
// byte or a tick, with a millisecond stamp) is taken whenever the four-entry
// job queue has room; lines are parsed as their bytes arrive. A count line runs
// the back end through two passes of the shared bit-serial divider, three more
// for the velocities when the time step is nonzero, and the CORDIC steps.
// Results leave through a registered output with valid/stall.
// Uses elo_pkg, elo_front, elo_queue and elo_back.
module encoder_line_odometry
  import elo_pkg::*;
#(
  parameter int LINE_LEN     = LINE_LEN_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  logic cfg_we, in_fire, push, pop, q_full, q_empty, discard_load;
  job_t push_job, pop_job;

  assign cfg_ready    = 1'b1;
  assign cfg_we       = cfg_valid && cfg_ready;
  assign discard_load = cfg_we && (cfg_index == CFG_FRAMES_DISC);
  assign in_stall     = q_full;
  assign in_fire      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wheel_circ_q16    <= RST_WHEEL_CIRC;
      cfg_r.track_width_q16   <= RST_TRACK_WIDTH;
      cfg_r.counts_per_rev    <= RST_COUNTS_REV;
      cfg_r.stale_timeout_ms  <= RST_STALE_TIMEOUT;
      cfg_r.frames_to_discard <= RST_FRAMES_DISC;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WHEEL_CIRC:    cfg_r.wheel_circ_q16    <= cfg_data;
        CFG_TRACK_WIDTH:   cfg_r.track_width_q16   <= cfg_data;
        CFG_COUNTS_REV:    cfg_r.counts_per_rev    <= cfg_data[15:0];
        CFG_STALE_TIMEOUT: cfg_r.stale_timeout_ms  <= cfg_data[15:0];
        CFG_FRAMES_DISC:   cfg_r.frames_to_discard <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  elo_front #(.LINE_LEN(LINE_LEN)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_item      (in_item),
    .cfg          (cfg_r),
    .discard_load (discard_load),
    .discard_val  (cfg_data[7:0]),
    .push         (push),
    .job          (push_job)
  );

  elo_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_job),
    .pop     (pop),
    .rd_data (pop_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  elo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_data    (pop_job),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== hw/rtl/elo_front.sv =====
// Front end: stale check, line assembly and on-the-fly count parsing.
// Uses elo_pkg; feeds elo_queue with one entry per input that causes results.
module elo_front
  import elo_pkg::*;
#(
  parameter int LINE_LEN = LINE_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  in_item_t   in_item,
  input  cfg_t       cfg,
  input  logic       discard_load,
  input  logic [7:0] discard_val,
  output logic       push,
  output job_t       job
);

  localparam int IW = $clog2(LINE_LEN);

  logic [IW-1:0] idx_r;
  logic          pfx_r;
  logic          colon_r;
  prs_t          rp_r, lp_r;
  logic [7:0]    discard_r;
  logic [31:0]   last_r;

  logic [31:0] dt_st, last_mid;
  logic        stale, is_byte, is_cr, qual, job_go;
  prs_t        feed_out;

  localparam prs_t PRS_RST = '{ph: PH_LEAD, neg: 1'b0, mag: 32'd0};

  function automatic prs_t feed(input prs_t p, input logic [7:0] ch);
    prs_t       r;
    logic       is_dig;
    logic [34:0] ext, m10;
    begin
      r      = p;
      is_dig = (ch >= CH_0) && (ch <= CH_9);
      ext    = {3'b0, p.mag};
      m10    = (ext << 3) + (ext << 1) + {31'b0, ch[3:0]};
      case (p.ph)
        PH_LEAD: begin
          if (ch inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D}) begin
            r.ph = PH_LEAD;
          end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            r.neg = (ch == CH_MINUS);
            r.ph  = PH_DIGIT;
          end else if (is_dig) begin
            r.mag = (m10 > 35'h080000000) ? 32'h80000000 : m10[31:0];
            r.ph  = PH_DIGIT;
          end else begin
            r.ph = PH_STOP;
          end
        end
        PH_DIGIT: begin
          if (is_dig) begin
            r.mag = (m10 > 35'h080000000) ? 32'h80000000 : m10[31:0];
          end else begin
            r.ph = PH_STOP;
          end
        end
        default: r = p;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] value(input prs_t p);
    begin
      if (p.neg) return 32'sd0 - $signed(p.mag);
      return p.mag[31] ? 32'sh7FFFFFFF : $signed(p.mag);
    end
  endfunction

  always_comb begin
    dt_st    = in_item.now_ms - last_r;
    stale    = dt_st >= {16'b0, cfg.stale_timeout_ms};
    last_mid = stale ? in_item.now_ms : last_r;
    is_byte  = in_fire && (in_item.req_type == REQ_BYTE);
    is_cr    = is_byte && (in_item.rx_byte == CH_CR);
    qual     = (idx_r > IW'(3)) && pfx_r;
    job_go   = is_cr && qual && (discard_r == 8'd0) && colon_r;
    push     = in_fire && (stale || job_go);
    job.has_rst = stale;
    job.has_job = job_go;
    job.right   = value(rp_r);
    job.left    = value(lp_r);
    job.dt      = in_item.now_ms - last_mid;
    feed_out    = feed(colon_r ? lp_r : rp_r, in_item.rx_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      pfx_r     <= 1'b1;
      colon_r   <= 1'b0;
      rp_r      <= PRS_RST;
      lp_r      <= PRS_RST;
      discard_r <= RST_FRAMES_DISC;
      last_r    <= 32'd0;
    end else if (discard_load) begin
      discard_r <= discard_val;
    end else if (in_fire) begin
      if (stale || job_go) last_r <= in_item.now_ms;
      if (is_cr) begin
        idx_r   <= '0;
        pfx_r   <= 1'b1;
        colon_r <= 1'b0;
        rp_r    <= PRS_RST;
        lp_r    <= PRS_RST;
        if (qual && discard_r != 8'd0) discard_r <= discard_r - 8'd1;
      end else if (is_byte && idx_r < IW'(LINE_LEN - 1)) begin
        idx_r <= idx_r + IW'(1);
        if (idx_r == IW'(0)) begin
          pfx_r <= (in_item.rx_byte == CH_C);
        end else if (idx_r == IW'(1)) begin
          pfx_r <= pfx_r && (in_item.rx_byte == CH_R);
        end else if (idx_r == IW'(2)) begin
          pfx_r <= pfx_r && (in_item.rx_byte == CH_EQ);
        end else if (!colon_r) begin
          if (in_item.rx_byte == CH_COLON) colon_r <= 1'b1;
          else rp_r <= feed_out;
        end else begin
          lp_r <= feed_out;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/elo_queue.sv =====
// Short job queue between the front end and the odometry back end.
// Uses elo_pkg for the entry type.
module elo_queue
  import elo_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_data,
  input  logic pop,
  output job_t rd_data,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == CW'(0));
  assign rd_data = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (pop)  rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      if (push && !pop) cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ===== hw/rtl/elo_div.sv =====
// Restoring long divider, one quotient bit per cycle.
// Uses elo_pkg for its default widths.
module elo_div
  import elo_pkg::*;
#(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int KW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r, dvs_r;
  logic [KW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   sh, diff;
  logic          ge;

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

  always_comb begin
    sh   = {rem_r, q_r[NW-1]};
    ge   = sh >= {1'b0, dvs_r};
    diff = sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= KW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - KW'(1);
        if (cnt_r == KW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : sh[DW-1:0];
    end
  end

endmodule

// ===== hw/rtl/elo_back.sv =====
// Back end: odometry sequencer with shared divider and iterative CORDIC.
// Uses elo_pkg and elo_div; drains elo_queue into the result register.
module elo_back
  import elo_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  job_t      q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CSW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RST    = 4'd1;
  localparam logic [3:0] ST_SUM    = 4'd2;
  localparam logic [3:0] ST_MLIN   = 4'd3;
  localparam logic [3:0] ST_DGO    = 4'd4;
  localparam logic [3:0] ST_DWAIT  = 4'd5;
  localparam logic [3:0] ST_MRAD   = 4'd6;
  localparam logic [3:0] ST_MDEN   = 4'd7;
  localparam logic [3:0] ST_MUNITS = 4'd8;
  localparam logic [3:0] ST_UNITS  = 4'd9;
  localparam logic [3:0] ST_MKX    = 4'd10;
  localparam logic [3:0] ST_KX     = 4'd11;
  localparam logic [3:0] ST_CORD   = 4'd12;
  localparam logic [3:0] ST_POS    = 4'd13;
  localparam logic [3:0] ST_VEL    = 4'd14;
  localparam logic [3:0] ST_OUT    = 4'd15;

  localparam logic [1:0] OP_LIN = 2'd0;
  localparam logic [1:0] OP_RAD = 2'd1;
  localparam logic [1:0] OP_VEL = 2'd2;

  localparam logic signed [33:0] QTURN = 34'sd1073741824;
  localparam logic signed [33:0] HTURN = 34'sd2147483648;

  logic [3:0]          st_r;
  job_t                job_r;
  logic signed [32:0]  s_r, d_r;
  logic [56:0]         mag_r;
  logic                sgn_r;
  logic [39:0]         den_r;
  logic [1:0]          op_r;
  logic signed [31:0]  lin_r, rad_r;
  logic signed [62:0]  prod_r;
  logic [15:0]         yaw_r, yaw_new_r;
  logic signed [33:0]  x_r, y_r, z_r;
  logic [CSW-1:0]      i_r;
  logic signed [31:0]  px_r, py_r, nx_r, ny_r;
  logic [1:0]          vi_r;
  logic signed [31:0]  vel_r [3];
  logic                out_valid_r;
  out_item_t           out_r;

  logic [15:0]         cpr;
  logic [23:0]         trk;
  logic                out_free, out_load;
  logic                div_start, div_busy, div_done;
  logic [DIV_NW-1:0]   div_n, div_q;
  logic [DIV_DW-1:0]   div_d;
  logic [32:0]         s_abs, d_abs, chg_abs;
  logic signed [32:0]  chg;
  logic [63:0]         rnd, rnd_k;
  logic [62:0]         prod_abs;
  logic [31:0]         m_rad;
  logic signed [33:0]  xk, z0, xs, ys;
  logic [15:0]         dyaw;

  function automatic logic signed [31:0] sat_mag(input logic [DIV_NW-1:0] q,
                                                 input logic neg);
    begin
      if (neg) return (q >= DIV_NW'(33'h080000000)) ? 32'sh80000000
                                                      : 32'sd0 - $signed(q[31:0]);
      return (q >= DIV_NW'(33'h080000000)) ? 32'sh7FFFFFFF : $signed(q[31:0]);
    end
  endfunction

  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    begin
      if (v > 35'sh07FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -35'sh080000000) return 32'sh80000000;
      return v[31:0];
    end
  endfunction

  elo_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    cpr      = (cfg.counts_per_rev == 16'd0) ? 16'd1 : cfg.counts_per_rev;
    trk      = (cfg.track_width_q16 == 24'd0) ? 24'd1 : cfg.track_width_q16;
    out_free = !out_valid_r || !out_stall;
    out_load = ((st_r == ST_RST) || (st_r == ST_OUT)) && out_free;
    q_pop    = (st_r == ST_IDLE) && !q_empty;
    div_start = (st_r == ST_DGO);
    s_abs    = s_r[32] ? 33'(-s_r) : 33'(s_r);
    d_abs    = d_r[32] ? 33'(-d_r) : 33'(d_r);
    case (vi_r)
      2'd0:    chg = 33'(nx_r) - 33'(px_r);
      2'd1:    chg = 33'(ny_r) - 33'(py_r);
      default: begin
        dyaw = yaw_new_r - yaw_r;
        chg  = 33'($signed(dyaw));
      end
    endcase
    if (vi_r != 2'd2) dyaw = yaw_new_r - yaw_r;
    chg_abs  = chg[32] ? 33'(-chg) : 33'(chg);
    prod_abs = prod_r[62] ? 63'(-prod_r) : 63'(prod_r);
    rnd      = {1'b0, prod_abs} + 64'h80000000;
    rnd_k    = {1'b0, prod_abs} + 64'h20000000;
    case (op_r)
      OP_LIN: begin
        div_n = DIV_NW'(mag_r) + DIV_NW'(cpr);
        div_d = DIV_DW'({cpr, 1'b0});
      end
      OP_RAD: begin
        div_n = (DIV_NW'(mag_r) << 16) + DIV_NW'(den_r >> 1);
        div_d = den_r;
      end
      default: begin
        div_n = DIV_NW'(mag_r) + DIV_NW'(job_r.dt >> 1);
        div_d = DIV_DW'(job_r.dt);
      end
    endcase
    m_rad = (div_q > DIV_NW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : div_q[31:0];
    xk    = prod_r[62] ? -34'($signed({1'b0, rnd_k[61:30]}))
                       : 34'($signed({1'b0, rnd_k[61:30]}));
    z0    = {{2{yaw_r[15]}}, yaw_r, 16'b0};
    xs    = x_r >>> i_r;
    ys    = y_r >>> i_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      px_r        <= 32'sd0;
      py_r        <= 32'sd0;
      yaw_r       <= 16'd0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (!q_empty) begin
            job_r <= q_data;
            st_r  <= q_data.has_rst ? ST_RST : ST_SUM;
          end
        end
        ST_RST: begin
          if (out_free) begin
            out_r <= {KIND_RESTART, 176'd0, !job_r.has_job};
            st_r  <= job_r.has_job ? ST_SUM : ST_IDLE;
          end
        end
        ST_SUM: begin
          s_r  <= 33'(job_r.right) + 33'(job_r.left);
          d_r  <= 33'(job_r.right) - 33'(job_r.left);
          st_r <= ST_MLIN;
        end
        ST_MLIN: begin
          mag_r <= s_abs * cfg.wheel_circ_q16;
          sgn_r <= s_r[32];
          op_r  <= OP_LIN;
          st_r  <= ST_DGO;
        end
        ST_DGO: st_r <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            case (op_r)
              OP_LIN: begin
                lin_r <= sat_mag(div_q, sgn_r);
                st_r  <= ST_MRAD;
              end
              OP_RAD: begin
                rad_r <= sgn_r ? 32'sd0 - $signed(m_rad) : $signed(m_rad);
                st_r  <= ST_MUNITS;
              end
              default: begin
                vel_r[vi_r] <= sat_mag(div_q, sgn_r);
                vi_r        <= vi_r + 2'd1;
                st_r        <= (vi_r == 2'd2) ? ST_OUT : ST_VEL;
              end
            endcase
          end
        end
        ST_MRAD: begin
          mag_r <= d_abs * cfg.wheel_circ_q16;
          sgn_r <= d_r[32];
          st_r  <= ST_MDEN;
        end
        ST_MDEN: begin
          den_r <= cpr * trk;
          op_r  <= OP_RAD;
          st_r  <= ST_DGO;
        end
        ST_MUNITS: begin
          prod_r <= rad_r * $signed({1'b0, INV_TWO_PI_Q32});
          st_r   <= ST_UNITS;
        end
        ST_UNITS: begin
          // heading step: rounded, only the low 16 bits matter
          yaw_new_r <= prod_r[62] ? yaw_r - rnd[47:32] : yaw_r + rnd[47:32];
          st_r      <= ST_MKX;
        end
        ST_MKX: begin
          prod_r <= lin_r * $signed({1'b0, KINV_Q30});
          st_r   <= ST_KX;
        end
        ST_KX: begin
          // fold headings past a quarter turn and negate the vector
          y_r <= 34'sd0;
          i_r <= '0;
          if (z0 > QTURN) begin
            z_r <= z0 - HTURN;
            x_r <= -xk;
          end else if (z0 < -QTURN) begin
            z_r <= z0 + HTURN;
            x_r <= -xk;
          end else begin
            z_r <= z0;
            x_r <= xk;
          end
          st_r <= ST_CORD;
        end
        ST_CORD: begin
          if (!z_r[33]) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - $signed({4'b0, atan_q32(5'(i_r))});
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + $signed({4'b0, atan_q32(5'(i_r))});
          end
          i_r <= i_r + CSW'(1);
          if (i_r == CSW'(CORDIC_STEPS - 1)) st_r <= ST_POS;
        end
        ST_POS: begin
          nx_r <= sat35(35'(px_r) + 35'(x_r));
          ny_r <= sat35(35'(py_r) + 35'(y_r));
          vi_r <= 2'd0;
          st_r <= ST_VEL;
        end
        ST_VEL: begin
          if (job_r.dt == 32'd0) begin
            vel_r[vi_r] <= 32'sd0;
            vi_r        <= vi_r + 2'd1;
            st_r        <= (vi_r == 2'd2) ? ST_OUT : ST_VEL;
          end else begin
            mag_r <= 57'(chg_abs) * 57'(MS_PER_S);
            sgn_r <= chg[32];
            op_r  <= OP_VEL;
            st_r  <= ST_DGO;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_r.kind     <= KIND_ODOM;
            out_r.pos_x    <= nx_r;
            out_r.pos_y    <= ny_r;
            out_r.heading  <= $signed(yaw_new_r);
            out_r.vel_x    <= vel_r[0];
            out_r.vel_y    <= vel_r[1];
            out_r.yaw_rate <= vel_r[2];
            out_r.last     <= 1'b1;
            px_r           <= nx_r;
            py_r           <= ny_r;
            yaw_r          <= yaw_new_r;
            st_r           <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue popped while empty");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DWAIT && !div_done) |-> div_busy)
    else $error("waiting on an idle divider");

endmodule

// ===== tb/tb_encoder_line_odometry.sv =====
// Self-checking testbench for encoder_line_odometry: serial count lines and ticks in,
// pose and velocity results out, checked against an in-bench odometry predictor.
// Depends on elo_pkg and encoder_line_odometry.
module tb_encoder_line_odometry;
  import elo_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int TAIL_CYCLES  = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WHEEL_CIRC;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  encoder_line_odometry dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state and configuration copy
  logic [23:0] circ_q16, track_q16;
  logic [15:0] cpr, stale_ms;
  logic [7:0]  discard_cfg, discard_cnt;
  logic [7:0]  line_chars [32];
  int          line_len;
  logic [31:0] prev_ms;
  longint      odo_x, odo_y;
  logic [15:0] odo_yaw;

  const longint cordic_atan [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  in_item_t  pending_items [$];
  out_item_t expected_poses [$];
  int errors = 0;
  int cycles = 0;
  int accepted_in = 0;
  int phase_no = 0;
  int phase_start_in = 0;
  bit hold_done = 0;
  bit in_taken = 0;
  int send_gap = 0;
  int recv_wait = 0;
  int long_hold = 0;
  logic [31:0] cur_ms;
  int made_items = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint div_near(longint num, longint den);
    longint q;
    q = ((num < 0 ? -num : num) + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint per_second(longint change, logic [31:0] dt);
    if (dt == 0) return 0;
    return sat32(div_near(change * 1000, longint'(dt)));
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == CH_CR;
  endfunction

  function automatic longint read_count(int p, int e);
    bit neg;
    longint mag;
    neg = 0;
    mag = 0;
    while (p < e && is_space(line_chars[p])) p++;
    if (p < e && (line_chars[p] == CH_PLUS || line_chars[p] == CH_MINUS)) begin
      neg = line_chars[p] == CH_MINUS;
      p++;
    end
    while (p < e && line_chars[p] >= CH_0 && line_chars[p] <= CH_9) begin
      mag = mag * 10 + longint'(line_chars[p] - CH_0);
      if (mag > 64'sd2147483648) mag = 64'sd2147483648;
      p++;
    end
    if (neg) return -mag;
    return mag > 64'sd2147483647 ? 64'sd2147483647 : mag;
  endfunction

  function automatic out_item_t odom_update(longint right, longint left, logic [31:0] now);
    longint cpr_e, trk_e, s, d, lin, rad, units, x, y, z, nx, ny, xs, ys;
    longint n, den, qi, rem, m, dyaw;
    logic [31:0] dt;
    logic [15:0] old_yaw, dy16;
    out_item_t r;
    cpr_e = cpr == 0 ? 1 : longint'(cpr);
    trk_e = track_q16 == 0 ? 1 : longint'(track_q16);
    dt = now - prev_ms;
    prev_ms = now;
    old_yaw = odo_yaw;
    s = right + left;
    d = right - left;
    lin = sat32(div_near(s * longint'(circ_q16), 2 * cpr_e));
    n = (d < 0 ? -d : d) * longint'(circ_q16);
    den = cpr_e * trk_e;
    qi = n / den;
    rem = n % den;
    if (qi >= 32768) m = 64'sd2147483647;
    else begin
      m = qi * 65536 + (rem * 65536 + den / 2) / den;
      if (m > 64'sd2147483647) m = 64'sd2147483647;
    end
    rad = d < 0 ? -m : m;
    units = div_near(rad * 683565276, longint'(1) <<< 32);
    x = div_near(lin * 652032874, longint'(1) <<< 30);
    y = 0;
    z = longint'($signed(old_yaw)) * 65536;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      x = -x;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      x = -x;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= cordic_atan[i];
      end else begin
        x += ys; y -= xs; z += cordic_atan[i];
      end
    end
    nx = sat32(odo_x + x);
    ny = sat32(odo_y + y);
    odo_yaw = old_yaw + units[15:0];
    dy16 = odo_yaw - old_yaw;
    dyaw = longint'($signed(dy16));
    r.kind = KIND_ODOM;
    r.pos_x = nx[31:0];
    r.pos_y = ny[31:0];
    r.heading = odo_yaw;
    r.vel_x = per_second(nx - odo_x, dt);
    r.vel_y = per_second(ny - odo_y, dt);
    r.yaw_rate = per_second(dyaw, dt);
    r.last = 1'b0;
    odo_x = nx;
    odo_y = ny;
    return r;
  endfunction

  function automatic void odom_predict_item(in_item_t it);
    out_item_t res [$];
    out_item_t r;
    if (it.now_ms - prev_ms >= {16'd0, stale_ms}) begin
      r = '0;
      r.kind = KIND_RESTART;
      res.push_back(r);
      prev_ms = it.now_ms;
    end
    if (it.req_type == REQ_BYTE) begin
      if (it.rx_byte == CH_CR) begin
        if (line_len > 3 && line_chars[0] == CH_C && line_chars[1] == CH_R &&
            line_chars[2] == CH_EQ) begin
          if (discard_cnt > 0) discard_cnt--;
          else begin
            for (int p = 3; p < line_len; p++) begin
              if (line_chars[p] == CH_COLON) begin
                res.push_back(odom_update(read_count(3, p), read_count(p + 1, line_len),
                                          it.now_ms));
                break;
              end
            end
          end
        end
        line_len = 0;
      end else if (line_len < 31) begin
        line_chars[line_len] = it.rx_byte;
        line_len++;
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_poses.push_back(res[i]);
  endfunction

  // Input acceptance and result check, both sampled at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_encoder_line_odometry: done, errors");
      $finish;
    end
    if (in_valid && !in_stall) begin
      odom_predict_item(in_item);
      in_taken = 1;
      accepted_in++;
    end
    if (out_valid && !out_stall) begin
      recv_wait = $urandom_range(0, 9);
      if ((recv_wait & 1) == 0 && $urandom_range(0, 3) != 0) recv_wait = 0;
      if (expected_poses.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction: %p", out_item);
      end else begin
        if (out_item !== expected_poses[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %p actual %p", expected_poses[0], out_item);
        end
        void'(expected_poses.pop_front());
      end
    end
  end

  // Input driver: hold a stalled transaction, otherwise idle or advance
  always @(negedge clk) begin
    if (!(in_valid && !in_taken)) begin
      in_taken = 0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver with one long hold-off while the input side keeps pushing
  always @(negedge clk) begin
    if (!hold_done && phase_no == 2 && accepted_in - phase_start_in >= 40) begin
      hold_done = 1;
      long_hold = 3000;
    end
    if (long_hold > 0) long_hold--;
    else if (recv_wait > 0) recv_wait--;
    out_stall <= (long_hold > 0) || (recv_wait > 0);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WHEEL_CIRC:    circ_q16 = val;
      CFG_TRACK_WIDTH:   track_q16 = val;
      CFG_COUNTS_REV:    cpr = val[15:0];
      CFG_STALE_TIMEOUT: stale_ms = val[15:0];
      CFG_FRAMES_DISC: begin
        discard_cfg = val[7:0];
        discard_cnt = val[7:0];
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_poses.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic push_item(logic rt, logic [7:0] b);
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) ;
    else if (pick < 96) cur_ms += $urandom_range(1, 3);
    else cur_ms += $urandom_range(500, 70000);
    it.req_type = rt;
    it.rx_byte = rt == REQ_BYTE ? b : 8'($urandom_range(0, 255));
    it.now_ms = cur_ms;
    pending_items.push_back(it);
    made_items++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(REQ_BYTE, s[i]);
  endtask

  function automatic string count_text();
    string s;
    int nd, pick;
    s = "";
    if ($urandom_range(0, 5) == 0) s = {s, ($urandom_range(0, 1) ? " " : "\t")};
    pick = $urandom_range(0, 3);
    if (pick == 0) s = {s, "-"};
    else if (pick == 1) s = {s, "+"};
    pick = $urandom_range(0, 9);
    nd = pick < 7 ? $urandom_range(1, 4) : (pick < 9 ? $urandom_range(5, 9) : 11);
    if ($urandom_range(0, 30) == 0) nd = 0;
    for (int i = 0; i < nd; i++) s = {s, string'(8'(CH_0 + $urandom_range(0, 9)))};
    return s;
  endfunction

  task automatic push_random(int n_items);
    int stop, pick;
    string s;
    stop = made_items + n_items;
    while (made_items < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        s = {"CR=", count_text(), ":", count_text()};
        if ($urandom_range(0, 15) == 0) s = {s, "  junk 0123456789 trailing"};
        push_text(s);
        push_item(REQ_BYTE, CH_CR);
      end else if (pick < 80) begin
        push_item(REQ_TICK, 8'h00);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 8)) push_item(REQ_BYTE, 8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        push_text({"CR=", count_text()});
        push_item(REQ_BYTE, CH_CR);
      end else begin
        push_text($urandom_range(0, 1) ? "CR=" : "CX=1:2");
        push_item(REQ_BYTE, CH_CR);
      end
    end
  endtask

  initial begin
    circ_q16 = RST_WHEEL_CIRC;
    track_q16 = RST_TRACK_WIDTH;
    cpr = RST_COUNTS_REV;
    stale_ms = RST_STALE_TIMEOUT;
    discard_cfg = RST_FRAMES_DISC;
    discard_cnt = RST_FRAMES_DISC;
    line_len = 0;
    prev_ms = '0;
    odo_x = 0;
    odo_y = 0;
    odo_yaw = '0;
    cur_ms = 32'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: discarded lines, an empty line, a stale jump, extremes
    phase_no = 0;
    push_text("CR=1:1"); push_item(REQ_BYTE, CH_CR);
    push_item(REQ_BYTE, CH_CR);
    cur_ms += 5000;
    push_item(REQ_TICK, 8'h00);
    wait_drained();
    write_reg(CFG_FRAMES_DISC, 24'd0);
    push_text("CR=+2147483647:-2147483648"); push_item(REQ_BYTE, CH_CR);
    push_text("CR=99999999999:x"); push_item(REQ_BYTE, CH_CR);
    push_text("CR=7"); push_item(REQ_BYTE, CH_CR);
    push_text("CR=  -40:  +25 and a line past the buffer end"); push_item(REQ_BYTE, CH_CR);
    push_random(200);
    wait_drained();

    // Large geometry, wrapping clock, longest timeout
    phase_no = 1;
    write_reg(CFG_WHEEL_CIRC, 24'hFFFFFF);
    write_reg(CFG_TRACK_WIDTH, 24'd1);
    write_reg(CFG_COUNTS_REV, 24'd1);
    write_reg(CFG_STALE_TIMEOUT, 24'd65535);
    write_reg(CFG_FRAMES_DISC, 24'd0);
    cur_ms = 32'hFFFF_F000;
    push_random(200);
    wait_drained();

    // Tiny geometry and a timeout that fires on almost every input
    phase_no = 2;
    phase_start_in = accepted_in;
    write_reg(CFG_WHEEL_CIRC, 24'd1);
    write_reg(CFG_TRACK_WIDTH, 24'hFFFFFF);
    write_reg(CFG_COUNTS_REV, 24'd65535);
    write_reg(CFG_STALE_TIMEOUT, 24'd1);
    write_reg(CFG_FRAMES_DISC, 24'd2);
    push_random(250);
    wait_drained();

    // Deepest discard count, then typical random geometry
    phase_no = 3;
    write_reg(CFG_FRAMES_DISC, 24'd255);
    push_random(60);
    wait_drained();
    phase_no = 4;
    write_reg(CFG_WHEEL_CIRC, 24'($urandom_range(20000, 200000)));
    write_reg(CFG_TRACK_WIDTH, 24'($urandom_range(20000, 200000)));
    write_reg(CFG_COUNTS_REV, 24'($urandom_range(100, 8192)));
    write_reg(CFG_STALE_TIMEOUT, 24'($urandom_range(20, 1500)));
    write_reg(CFG_FRAMES_DISC, 24'd1);
    push_random(600);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_poses.size() == 0) begin
      $display("tb_encoder_line_odometry: done, clean");
    end else begin
      $display("tb_encoder_line_odometry: done, errors");
    end
    $finish;
  end

endmodule

// ===== encoder_line_odometry.f =====
hw/rtl/elo_pkg.sv
hw/rtl/elo_front.sv
hw/rtl/elo_queue.sv
hw/rtl/elo_div.sv
hw/rtl/elo_back.sv
hw/rtl/encoder_line_odometry.sv
tb/tb_encoder_line_odometry.sv
